// File: sv/kfa_pkg.sv
// Shared types, constants and helpers for the kinematic frame stepper.
package kfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_SHIFT = 16;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MAX_SPEED = 3'd0;
  localparam logic [2:0] REG_ACCEL     = 3'd1;
  localparam logic [2:0] REG_FRICTION  = 3'd2;
  localparam logic [2:0] REG_GRAVITY   = 3'd3;
  localparam logic [2:0] REG_AIR       = 3'd4;
  localparam logic [2:0] REG_ENABLE    = 3'd5;

  // Reset values in whole units, scaled by the fraction bits at the top level; the air factor is raw
  localparam int MAX_SPEED_UNITS = 5;
  localparam int ACCEL_UNITS     = 50;
  localparam int FRICTION_UNITS  = 15;
  localparam int GRAVITY_UNITS   = -10;
  localparam logic [16:0] AIR_FACTOR_RST = 17'd19661;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/kfa_iter.sv
// Shared iterative unit: 64-bit square root or 64/32 division, one bit a cycle.
module kfa_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfa_pkg::iter_req_t  req_i,
  input  logic [63:0]         opa_i,
  input  logic [31:0]         opb_i,
  output logic                done_o,
  output logic [31:0]         res_o
);

  logic [35:0]       rem_q, rem_d;
  logic [63:0]       src_q, src_d;
  logic [31:0]       res_q, res_d;
  logic [31:0]       den_q, den_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  kfa_pkg::iter_op_e op_q, op_d;

  logic [35:0] rem_ext, trial, diff;
  logic        ge;

  always_comb begin
    unique case (op_q)
      kfa_pkg::OP_SQRT: begin
        rem_ext = {rem_q[33:0], src_q[63:62]};
        trial   = {2'b00, res_q, 2'b01};
      end
      kfa_pkg::OP_DIV: begin
        rem_ext = {3'b000, rem_q[31:0], src_q[63]};
        trial   = {4'b0000, den_q};
      end
      default: begin
        rem_ext = '0;
        trial   = '0;
      end
    endcase
    diff = rem_ext - trial;
    ge   = (rem_ext >= trial);
  end

  always_comb begin
    rem_d  = rem_q;
    src_d  = src_q;
    res_d  = res_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      op_d   = req_i.op;
      busy_d = 1'b1;
      cnt_d  = '0;
      res_d  = '0;
      den_d  = opb_i;
      if (req_i.op == kfa_pkg::OP_SQRT) begin
        rem_d = '0;
        src_d = opa_i;
      end else begin
        rem_d = {4'b0000, opa_i[63:32]};
        src_d = {opa_i[31:0], 32'd0};
      end
    end else if (busy_q) begin
      rem_d = ge ? diff : rem_ext;
      res_d = {res_q[30:0], ge};
      src_d = (op_q == kfa_pkg::OP_SQRT) ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= kfa_pkg::OP_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    src_q <= src_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: sv/kinematic_friction_accel_step.sv
// Top level of the kinematic frame stepper: registers, sequencer, shared multiplier.
//
// One input transfer is one game frame (time step, direction, optional jump).
// The block holds position, velocity and the grounded flag and returns one
// result transfer per frame carrying the state after that frame.
// Input and output channels use valid/ready; the configuration port is a
// plain write (enable, index, data) taken on any clock edge, intended only
// while no frame is in flight. Unknown indexes are ignored.
// A disabled frame only computes the speed (two squares, one square root).
// An enabled frame runs up to three square roots and four divisions on the
// shared bit-serial unit (32 steps each) and its products on the single
// 33x33 multiplier. The next frame is taken in the cycle after the current
// one has been handed to the output register.
// A result waits in the output register while the receiver stalls; the next
// frame is already accepted and computed meanwhile, and only its final
// hand-over waits for the register to empty.
// Reset (asynchronous, active low) zeroes position and velocity, marks the
// body airborne and loads the default register values.
module kinematic_friction_accel_step #(
  parameter int FracBits = kfa_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        time_step_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_z_i,
  input  logic               jump_request_i,
  input  logic signed [31:0] jump_speed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic [30:0]        pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic [30:0]        speed_o,
  output logic               grounded_o
);

  localparam logic [30:0] MaxSpeedRst = 31'(kfa_pkg::MAX_SPEED_UNITS <<< FracBits);
  localparam logic [30:0] AccelRst    = 31'(kfa_pkg::ACCEL_UNITS <<< FracBits);
  localparam logic [30:0] FrictionRst = 31'(kfa_pkg::FRICTION_UNITS <<< FracBits);
  localparam logic [31:0] GravityRst  = 32'(kfa_pkg::GRAVITY_UNITS * (1 <<< FracBits));

  // Sequencer states
  localparam logic [5:0] S_IDLE    = 6'd0;
  localparam logic [5:0] S_G_MUL   = 6'd1;
  localparam logic [5:0] S_G_ADD   = 6'd2;
  localparam logic [5:0] S_H_X     = 6'd3;
  localparam logic [5:0] S_H_Z     = 6'd4;
  localparam logic [5:0] S_H_S     = 6'd5;
  localparam logic [5:0] S_H_W     = 6'd6;
  localparam logic [5:0] S_F_LEN   = 6'd7;
  localparam logic [5:0] S_F_M1    = 6'd8;
  localparam logic [5:0] S_F_M2    = 6'd9;
  localparam logic [5:0] S_F_AIR   = 6'd10;
  localparam logic [5:0] S_F_AIRW  = 6'd11;
  localparam logic [5:0] S_F_CMP   = 6'd12;
  localparam logic [5:0] S_RS_MUL  = 6'd13;
  localparam logic [5:0] S_RS_DIV  = 6'd14;
  localparam logic [5:0] S_RS_WAIT = 6'd15;
  localparam logic [5:0] S_A_CHK   = 6'd16;
  localparam logic [5:0] S_A_M1    = 6'd17;
  localparam logic [5:0] S_A_M2    = 6'd18;
  localparam logic [5:0] S_A_AIR   = 6'd19;
  localparam logic [5:0] S_A_AIRW  = 6'd20;
  localparam logic [5:0] S_A_DX    = 6'd21;
  localparam logic [5:0] S_A_DXW   = 6'd22;
  localparam logic [5:0] S_A_DZ    = 6'd23;
  localparam logic [5:0] S_A_DZW   = 6'd24;
  localparam logic [5:0] S_A_NL    = 6'd25;
  localparam logic [5:0] S_P_Y     = 6'd26;
  localparam logic [5:0] S_P_YW    = 6'd27;
  localparam logic [5:0] S_P_X     = 6'd28;
  localparam logic [5:0] S_P_XW    = 6'd29;
  localparam logic [5:0] S_P_Z     = 6'd30;
  localparam logic [5:0] S_P_ZW    = 6'd31;
  localparam logic [5:0] S_OUT     = 6'd32;

  // Configuration
  logic [30:0]        max_q, acc_q, fr_q;
  logic signed [31:0] grav_q;
  logic [16:0]        af_q;
  logic               en_q;

  // Body state
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic               og_q, og_d;

  // Frame operands and working registers
  logic [15:0]        dt_q, dt_d;
  logic signed [17:0] dx_q, dx_d, dz_q, dz_d;
  logic [5:0]         st_q, st_d, ret_q, ret_d;
  logic               comp_q, comp_d, clamp_q, clamp_d;
  logic [31:0]        len_q, len_d, f_q, f_d;
  logic [63:0]        sq_q, sq_d;
  logic signed [65:0] prod_q, prod_d;

  // Output register
  logic               out_valid_q, out_valid_d, out_load;
  logic signed [31:0] o_px_q, o_pz_q, o_vx_q, o_vy_q, o_vz_q;
  logic [30:0]        o_py_q, o_sp_q;
  logic               o_gr_q;

  // Shared multiplier and iterative unit
  logic signed [32:0] mul_a, mul_b;
  kfa_pkg::iter_req_t iter_req;
  logic [63:0]        iter_opa;
  logic [31:0]        iter_opb, iter_res;
  logic               iter_done;

  logic signed [31:0] vc;
  logic signed [32:0] vc33, vmag;
  logic signed [65:0] q66, sum66;
  logic               accept;

  kfa_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .opa_i  (iter_opa),
    .opb_i  (iter_opb),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  assign in_ready_o = (st_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Component under rescale, and its magnitude
  assign vc   = comp_q ? vz_q : vx_q;
  assign vc33 = 33'(vc);
  assign vmag = vc33[32] ? -vc33 : vc33;
  assign q66  = $signed({34'd0, iter_res});

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_G_MUL:  begin mul_a = 33'(grav_q);            mul_b = $signed({17'd0, dt_q}); end
      S_H_X:    begin mul_a = 33'(vx_q);              mul_b = 33'(vx_q);              end
      S_H_Z:    begin mul_a = 33'(vz_q);              mul_b = 33'(vz_q);              end
      S_F_M1:   begin mul_a = $signed({2'd0, fr_q});  mul_b = $signed({17'd0, dt_q}); end
      S_A_M1:   begin mul_a = $signed({2'd0, acc_q}); mul_b = $signed({17'd0, dt_q}); end
      S_F_AIR,
      S_A_AIR:  begin mul_a = $signed({1'b0, f_q});   mul_b = $signed({16'd0, af_q}); end
      S_RS_MUL: begin mul_a = vmag;                   mul_b = $signed({1'b0, f_q});   end
      S_A_DX:   begin mul_a = 33'(dx_q);              mul_b = $signed({1'b0, f_q});   end
      S_A_DZ:   begin mul_a = 33'(dz_q);              mul_b = $signed({1'b0, f_q});   end
      S_P_Y:    begin mul_a = 33'(vy_q);              mul_b = $signed({17'd0, dt_q}); end
      S_P_X:    begin mul_a = 33'(vx_q);              mul_b = $signed({17'd0, dt_q}); end
      S_P_Z:    begin mul_a = 33'(vz_q);              mul_b = $signed({17'd0, dt_q}); end
      default:  begin mul_a = '0;                     mul_b = '0;                     end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    st_d        = st_q;
    ret_d       = ret_q;
    comp_d      = comp_q;
    clamp_d     = clamp_q;
    len_d       = len_q;
    f_d         = f_q;
    sq_d        = sq_q;
    dt_d        = dt_q;
    dx_d        = dx_q;
    dz_d        = dz_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    og_d        = og_q;
    iter_req    = '{start: 1'b0, op: kfa_pkg::OP_SQRT};
    iter_opa    = {sq_q + prod_q[63:0]};
    iter_opb    = len_q;
    out_load    = 1'b0;
    sum66       = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          dt_d = time_step_i;
          dx_d = dir_x_i;
          dz_d = dir_z_i;
          if (en_q) begin
            if (jump_request_i) begin
              vy_d = jump_speed_i;
            end
            st_d = S_G_MUL;
          end else begin
            ret_d = S_OUT;
            st_d  = S_H_X;
          end
        end
      end
      S_G_MUL: st_d = S_G_ADD;
      S_G_ADD: begin
        vy_d  = kfa_pkg::sat32(66'(vy_q) + (prod_q >>> kfa_pkg::TIME_SHIFT));
        ret_d = S_F_LEN;
        st_d  = S_H_X;
      end
      // horizontal length: squares, then square root
      S_H_X: st_d = S_H_Z;
      S_H_Z: begin
        sq_d = prod_q[63:0];
        st_d = S_H_S;
      end
      S_H_S: begin
        iter_req = '{start: 1'b1, op: kfa_pkg::OP_SQRT};
        st_d     = S_H_W;
      end
      S_H_W: begin
        if (iter_done) begin
          st_d = ret_q;
        end
      end
      // friction
      S_F_LEN: begin
        len_d = iter_res;
        st_d  = (iter_res == 32'd0) ? S_A_CHK : S_F_M1;
      end
      S_F_M1: st_d = S_F_M2;
      S_F_M2: begin
        f_d  = prod_q[47:16];
        st_d = og_q ? S_F_CMP : S_F_AIR;
      end
      S_F_AIR: st_d = S_F_AIRW;
      S_F_AIRW: begin
        f_d  = prod_q[47:16];
        st_d = S_F_CMP;
      end
      S_F_CMP: begin
        if (len_q > f_q) begin
          comp_d  = 1'b0;
          clamp_d = 1'b0;
          st_d    = S_RS_MUL;
        end else begin
          vx_d = '0;
          vz_d = '0;
          st_d = S_A_CHK;
        end
      end
      // rescale of x then z by f / len, on magnitudes; friction subtracts the scaled part
      S_RS_MUL: st_d = S_RS_DIV;
      S_RS_DIV: begin
        iter_req = '{start: 1'b1, op: kfa_pkg::OP_DIV};
        iter_opa = prod_q[63:0];
        st_d     = S_RS_WAIT;
      end
      S_RS_WAIT: begin
        if (iter_done) begin
          if (clamp_q) begin
            sum66 = vc[31] ? -q66 : q66;
          end else begin
            sum66 = 66'(vc) - (vc[31] ? -q66 : q66);
          end
          if (comp_q) begin
            vz_d = kfa_pkg::sat32(sum66);
            st_d = clamp_q ? S_P_Y : S_A_CHK;
          end else begin
            vx_d   = kfa_pkg::sat32(sum66);
            comp_d = 1'b1;
            st_d   = S_RS_MUL;
          end
        end
      end
      // acceleration
      S_A_CHK: begin
        if ((len_q <= {1'b0, max_q}) && ((dx_q != '0) || (dz_q != '0))) begin
          st_d = S_A_M1;
        end else begin
          st_d = S_P_Y;
        end
      end
      S_A_M1: st_d = S_A_M2;
      S_A_M2: begin
        f_d  = prod_q[47:16];
        st_d = og_q ? S_A_DX : S_A_AIR;
      end
      S_A_AIR: st_d = S_A_AIRW;
      S_A_AIRW: begin
        f_d  = prod_q[47:16];
        st_d = S_A_DX;
      end
      S_A_DX: st_d = S_A_DXW;
      S_A_DXW: begin
        vx_d = kfa_pkg::sat32(66'(vx_q) + (prod_q >>> FracBits));
        st_d = S_A_DZ;
      end
      S_A_DZ: st_d = S_A_DZW;
      S_A_DZW: begin
        vz_d  = kfa_pkg::sat32(66'(vz_q) + (prod_q >>> FracBits));
        ret_d = S_A_NL;
        st_d  = S_H_X;
      end
      S_A_NL: begin
        if (iter_res > {1'b0, max_q}) begin
          len_d   = iter_res;
          f_d     = {1'b0, max_q};
          comp_d  = 1'b0;
          clamp_d = 1'b1;
          st_d    = S_RS_MUL;
        end else begin
          st_d = S_P_Y;
        end
      end
      // integrate position; a hit on the floor sets grounded, any other result clears it
      S_P_Y: st_d = S_P_YW;
      S_P_YW: begin
        sum66 = 66'(py_q) + (prod_q >>> kfa_pkg::TIME_SHIFT);
        if (sum66 < 0) begin
          py_d = '0;
          og_d = 1'b1;
          vy_d = '0;
        end else begin
          py_d = kfa_pkg::sat32(sum66);
          og_d = 1'b0;
        end
        st_d = S_P_X;
      end
      S_P_X: st_d = S_P_XW;
      S_P_XW: begin
        px_d = kfa_pkg::sat32(66'(px_q) + (prod_q >>> kfa_pkg::TIME_SHIFT));
        st_d = S_P_Z;
      end
      S_P_Z: st_d = S_P_ZW;
      S_P_ZW: begin
        pz_d  = kfa_pkg::sat32(66'(pz_q) + (prod_q >>> kfa_pkg::TIME_SHIFT));
        ret_d = S_OUT;
        st_d  = S_H_X;
      end
      // hand over once the output register is free or is read in this cycle
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      comp_q      <= 1'b0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      og_q        <= 1'b0;
      max_q       <= MaxSpeedRst;
      acc_q       <= AccelRst;
      fr_q        <= FrictionRst;
      grav_q      <= GravityRst;
      af_q        <= kfa_pkg::AIR_FACTOR_RST;
      en_q        <= 1'b1;
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      comp_q      <= comp_d;
      clamp_q     <= clamp_d;
      out_valid_q <= out_valid_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pz_q        <= pz_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      vz_q        <= vz_d;
      og_q        <= og_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kfa_pkg::REG_MAX_SPEED: max_q  <= cfg_data_i[30:0];
          kfa_pkg::REG_ACCEL:     acc_q  <= cfg_data_i[30:0];
          kfa_pkg::REG_FRICTION:  fr_q   <= cfg_data_i[30:0];
          kfa_pkg::REG_GRAVITY:   grav_q <= cfg_data_i;
          kfa_pkg::REG_AIR:       af_q   <= cfg_data_i[16:0];
          kfa_pkg::REG_ENABLE:    en_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    dx_q   <= dx_d;
    dz_q   <= dz_d;
    len_q  <= len_d;
    f_q    <= f_d;
    sq_q   <= sq_d;
    prod_q <= prod_d;
    if (out_load) begin
      o_px_q <= px_q;
      o_py_q <= py_q[31] ? 31'd0 : py_q[30:0];
      o_pz_q <= pz_q;
      o_vx_q <= vx_q;
      o_vy_q <= vy_q;
      o_vz_q <= vz_q;
      o_sp_q <= iter_res[31] ? 31'h7FFF_FFFF : iter_res[30:0];
      o_gr_q <= og_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = o_px_q;
  assign pos_y_o     = o_py_q;
  assign pos_z_o     = o_pz_q;
  assign vel_x_o     = o_vx_q;
  assign vel_y_o     = o_vy_q;
  assign vel_z_o     = o_vz_q;
  assign speed_o     = o_sp_q;
  assign grounded_o  = o_gr_q;

endmodule

// File: test/kinematic_friction_accel_step_tb.sv
// Self-checking testbench for the kinematic frame stepper: predicted state after each frame.
module kinematic_friction_accel_step_tb;
  import kfa_pkg::*;

  // Result fields of one frame, in port order
  typedef struct {
    logic signed [31:0] pos_x;
    logic [30:0]        pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        speed;
    logic               grounded;
  } frame_state_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = REG_MAX_SPEED;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [15:0]        time_step_i = '0;
  logic signed [17:0] dir_x_i = '0;
  logic signed [17:0] dir_z_i = '0;
  logic               jump_request_i = 1'b0;
  logic signed [31:0] jump_speed_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic [30:0]        pos_y_o, speed_o;
  logic               grounded_o;

  kinematic_friction_accel_step DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: registers and body state
  longint unsigned mdl_max_speed, mdl_accel, mdl_friction, mdl_air;
  longint          mdl_gravity;
  bit              mdl_enable;
  longint          body_pos [3];
  longint          body_vel [3];
  bit              body_on_ground;

  frame_state_t expected_frames[$];
  int  error_count = 0;
  int  frames_sent = 0;
  int  frames_checked = 0;
  int  cfg_writes = 0;
  longint cycle_count = 0;
  bit  stall_heavy = 1'b0;

  // Floor shift: rounds toward minus infinity
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned horiz_len();
    longint unsigned ax = magnitude(body_vel[0]);
    longint unsigned az = magnitude(body_vel[2]);
    return int_sqrt(ax * ax + az * az);
  endfunction

  // Scale a velocity by num/den on its magnitude, toward zero
  function automatic longint scale_toward_zero(longint v, longint unsigned num,
                                               longint unsigned den);
    longint unsigned q = (magnitude(v) * num) / den;
    return (v < 0) ? clip32(-longint'(q)) : clip32(longint'(q));
  endfunction

  task automatic model_reset();
    mdl_max_speed = 64'd5 << FRAC_BITS;
    mdl_accel = 64'd50 << FRAC_BITS;
    mdl_friction = 64'd15 << FRAC_BITS;
    mdl_gravity = -(64'sd10 << FRAC_BITS);
    mdl_air = 64'd19661;
    mdl_enable = 1'b1;
    for (int i = 0; i < 3; i++) begin
      body_pos[i] = 0;
      body_vel[i] = 0;
    end
    body_on_ground = 1'b0;
  endtask

  // Advance the predicted body by one frame and queue the outcome
  task automatic predict_frame(logic [15:0] dt_in, logic signed [17:0] dx_in,
                               logic signed [17:0] dz_in, logic jump,
                               logic signed [31:0] jspeed);
    longint dt, dx, dz, a, py;
    longint unsigned len, f, nl, sp;
    frame_state_t fs;
    dt = longint'(dt_in);
    dx = longint'(dx_in);
    dz = longint'(dz_in);
    if (mdl_enable) begin
      if (jump) body_vel[1] = longint'(jspeed);
      body_vel[1] = clip32(body_vel[1] + floor_shr(mdl_gravity * dt, TIME_SHIFT));
      len = horiz_len();
      if (len > 0) begin
        f = (mdl_friction * longint'(dt)) >> TIME_SHIFT;
        if (!body_on_ground) f = (f * mdl_air) >> TIME_SHIFT;
        if (len > f) begin
          body_vel[0] = clip32(body_vel[0] - scale_toward_zero(body_vel[0], f, len));
          body_vel[2] = clip32(body_vel[2] - scale_toward_zero(body_vel[2], f, len));
        end else begin
          body_vel[0] = 0;
          body_vel[2] = 0;
        end
      end
      if (len <= mdl_max_speed && (dx != 0 || dz != 0)) begin
        a = longint'((mdl_accel * longint'(dt)) >> TIME_SHIFT);
        if (!body_on_ground) a = longint'((longint'(a) * mdl_air) >> TIME_SHIFT);
        body_vel[0] = clip32(body_vel[0] + floor_shr(dx * a, FRAC_BITS));
        body_vel[2] = clip32(body_vel[2] + floor_shr(dz * a, FRAC_BITS));
        nl = horiz_len();
        if (nl > mdl_max_speed) begin
          body_vel[0] = scale_toward_zero(body_vel[0], mdl_max_speed, nl);
          body_vel[2] = scale_toward_zero(body_vel[2], mdl_max_speed, nl);
        end
      end
      py = body_pos[1] + floor_shr(body_vel[1] * dt, TIME_SHIFT);
      if (py < 0) begin
        body_pos[1] = 0;
        body_on_ground = 1'b1;
        body_vel[1] = 0;
      end else begin
        body_pos[1] = clip32(py);
        body_on_ground = 1'b0;
      end
      body_pos[0] = clip32(body_pos[0] + floor_shr(body_vel[0] * dt, TIME_SHIFT));
      body_pos[2] = clip32(body_pos[2] + floor_shr(body_vel[2] * dt, TIME_SHIFT));
    end
    sp = horiz_len();
    if (sp > 64'h7FFF_FFFF) sp = 64'h7FFF_FFFF;
    fs.pos_x = body_pos[0][31:0];
    fs.pos_y = (body_pos[1] < 0) ? '0 : body_pos[1][30:0];
    fs.pos_z = body_pos[2][31:0];
    fs.vel_x = body_vel[0][31:0];
    fs.vel_y = body_vel[1][31:0];
    fs.vel_z = body_vel[2][31:0];
    fs.speed = sp[30:0];
    fs.grounded = body_on_ground;
    expected_frames.push_back(fs);
  endtask

  // Register write: one cycle of write enable, mirrored in the predictor
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_MAX_SPEED: mdl_max_speed = data & 32'h7FFF_FFFF;
      REG_ACCEL:     mdl_accel = data & 32'h7FFF_FFFF;
      REG_FRICTION:  mdl_friction = data & 32'h7FFF_FFFF;
      REG_GRAVITY:   mdl_gravity = longint'(signed'(data));
      REG_AIR:       mdl_air = data & 32'h1_FFFF;
      REG_ENABLE:    mdl_enable = data[0];
      default: ;
    endcase
  endtask

  // Wait until every queued frame is back, then let the block settle
  task automatic drain();
    wait (expected_frames.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  // Offer one frame; valid stays high until the transfer
  task automatic send_frame(logic [15:0] dt, logic signed [17:0] dx,
                            logic signed [17:0] dz, logic jump,
                            logic signed [31:0] jspeed);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    time_step_i <= dt;
    dir_x_i <= dx;
    dir_z_i <= dz;
    jump_request_i <= jump;
    jump_speed_i <= jspeed;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame(dt, dx, dz, jump, jspeed);
    frames_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [17:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 18'sd0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      default: return 18'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Random frames in bursts, mostly game-like, some extreme
  task automatic random_frames(int n);
    int burst;
    logic [15:0] dt;
    logic signed [31:0] js;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n > 0; k++, n--) begin
        dt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(500, 2200));
        js = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 600000));
        send_frame(dt, rand_dir(), rand_dir(), $urandom_range(0, 5) == 0, js);
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
  endtask

  task automatic test_reset_defaults();
    send_frame(16'd1092, 18'sd0, 18'sd0, 1'b0, 32'sd0);
    send_frame(16'd1092, 18'sd65536, 18'sd0, 1'b1, 32'sd393216);
    for (int i = 0; i < 6; i++) send_frame(16'd1092, 18'sd46341, -18'sd46341, 1'b0, 32'sd0);
  endtask

  task automatic test_directed_extremes();
    // floor landing, friction to a halt, zero direction, extreme fields
    send_frame(16'hFFFF, -18'sd65536, 18'sd65536, 1'b0, 32'sd0);
    send_frame(16'hFFFF, 18'sd0, 18'sd0, 1'b0, 32'sd0);
    send_frame(16'd0, 18'sd65536, 18'sd65536, 1'b1, 32'sh7FFF_FFFF);
    send_frame(16'hFFFF, 18'sd0, 18'sd0, 1'b0, 32'sd0);
    send_frame(16'hFFFF, 18'sd0, 18'sd0, 1'b1, 32'sh8000_0000);
    send_frame(16'h8000, -18'sd1, 18'sd1, 1'b1, 32'sh7FFF_FFFF);
    send_frame(16'h0001, 18'sd65535, -18'sd65535, 1'b0, 32'sd0);
    drain();
    write_reg(REG_MAX_SPEED, 32'h7FFF_FFFF);
    write_reg(REG_ACCEL, 32'h7FFF_FFFF);
    write_reg(REG_FRICTION, 32'd0);
    write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
    write_reg(REG_AIR, 32'h1_FFFF);
    for (int i = 0; i < 5; i++) send_frame(16'hFFFF, 18'sd65536, -18'sd65536, 1'b0, 32'sd0);
    drain();
    write_reg(REG_GRAVITY, 32'h8000_0000);
    write_reg(REG_FRICTION, 32'h7FFF_FFFF);
    write_reg(REG_AIR, 32'd0);
    for (int i = 0; i < 4; i++) send_frame(16'hFFFF, -18'sd65536, 18'sd65536, 1'b0, 32'sd0);
    drain();
  endtask

  task automatic test_disabled();
    write_reg(REG_ENABLE, 32'd0);
    send_frame(16'hFFFF, 18'sd65536, 18'sd65536, 1'b1, 32'sd1000000);
    send_frame(16'd1092, -18'sd65536, 18'sd0, 1'b0, 32'sd0);
    drain();
    write_reg(REG_ENABLE, 32'd1);
  endtask

  task automatic test_random_settings();
    // defaults, then random register sets with extremes mixed in
    write_reg(REG_MAX_SPEED, 32'd5 << FRAC_BITS);
    write_reg(REG_ACCEL, 32'd50 << FRAC_BITS);
    write_reg(REG_FRICTION, 32'd15 << FRAC_BITS);
    write_reg(REG_GRAVITY, -(32'sd10 << FRAC_BITS));
    write_reg(REG_AIR, 32'd19661);
    random_frames(250);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_MAX_SPEED, (p == 0) ? 32'd0 : 32'($urandom_range(0, 32'h00FF_FFFF)));
      write_reg(REG_ACCEL, (p == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 32'h0FFF_FFFF)));
      write_reg(REG_FRICTION, 32'($urandom) & 32'h7FFF_FFFF >> $urandom_range(0, 12));
      write_reg(REG_GRAVITY, (p == 2) ? 32'd0 : 32'($urandom) >>> $urandom_range(0, 10));
      write_reg(REG_AIR, 32'($urandom_range(0, 131071)));
      write_reg(REG_ENABLE, (p == 3) ? 32'd0 : 32'd1);
      random_frames(80);
      drain();
    end
    write_reg(REG_ENABLE, 32'd1);
  endtask

  // Receiver stalls: alternating calm and busy spells
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_heavy <= ~stall_heavy;
    out_ready_i <= stall_heavy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  // Result checker: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    frame_state_t exp_fs;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result transfer, pos_x %0d", $time, pos_x_o);
        error_count++;
      end else begin
        exp_fs = expected_frames.pop_front();
        frames_checked++;
        if ({pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o, speed_o, grounded_o} !==
            {exp_fs.pos_x, exp_fs.pos_y, exp_fs.pos_z, exp_fs.vel_x, exp_fs.vel_y,
             exp_fs.vel_z, exp_fs.speed, exp_fs.grounded}) begin
          error_count++;
          $display("%0t: pos exp %0d %0d %0d got %0d %0d %0d", $time, exp_fs.pos_x,
                   exp_fs.pos_y, exp_fs.pos_z, pos_x_o, pos_y_o, pos_z_o);
          $display("%0t: vel exp %0d %0d %0d got %0d %0d %0d", $time, exp_fs.vel_x,
                   exp_fs.vel_y, exp_fs.vel_z, vel_x_o, vel_y_o, vel_z_o);
          $display("%0t: speed/grounded exp %0d %0b got %0d %0b", $time, exp_fs.speed,
                   exp_fs.grounded, speed_o, grounded_o);
        end
      end
    end
  end

  // Watchdog: bounds the run of ~700 frames plus heavy output stalls
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 2_000_000) begin
      $display("%0t: timeout, %0d frames still outstanding", $time, expected_frames.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_disabled();
    test_random_settings();
    drain();
    $display("Frames sent %0d, results checked %0d, register writes %0d,", frames_sent,
             frames_checked, cfg_writes);
    $display("covering jumps, landings, friction stops, speed clamps and disabled frames.");
    if (error_count == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/kfa_pkg.sv
sv/kfa_iter.sv
sv/kinematic_friction_accel_step.sv
test/kinematic_friction_accel_step_tb.sv
